// File: rtl/break_bitmap_bin_enumerator_core_assert.svh
// Assertion macros shared by the checker of the break bitmap bin enumerator.
`ifndef BREAK_BITMAP_BIN_ENUMERATOR_CORE_ASSERT_SVH
`define BREAK_BITMAP_BIN_ENUMERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bbbe_pkg.sv
// Shared constants, codes and types of the break bitmap bin enumerator.
package bbbe_pkg;

    localparam int MAX_BREAKS = 63;
    localparam int MAP_W      = MAX_BREAKS;
    localparam int BIT_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int FUNC_W     = 2;

    localparam logic [BIT_W-1:0] PIU_RESET = BIT_W'(63);

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LIST
    } state_t;

    // Result of the find-lowest-set unit.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
        logic [MAP_W-1:0] rest;
    } ffs_res_t;

endpackage

// File: rtl/bbbe_ffs.sv
// Find-lowest-set unit: locates the lowest set bit of the scan word and clears it.
module bbbe_ffs (
    input  logic [bbbe_pkg::MAP_W-1:0] vec,
    output bbbe_pkg::ffs_res_t         res
);
    import bbbe_pkg::*;

    logic [MAP_W-1:0] dec;
    logic [MAP_W-1:0] low;
    logic [BIT_W-1:0] idx;

    // One subtraction serves both the isolated lowest bit and the remainder.
    assign dec = vec - MAP_W'(1);
    assign low = vec & ~dec;

    always_comb begin
        idx = '0;
        for (int i = 0; i < MAP_W; i++) begin
            idx = idx | ({BIT_W{low[i]}} & BIT_W'(i));
        end
    end

    assign res.found = |vec;
    assign res.idx   = idx;
    assign res.rest  = vec & dec;

endmodule

// File: rtl/break_bitmap_bin_enumerator_core.sv
// Top level of the break bitmap bin enumerator: sequencer, state and output register.
// An insert, remove or toggle transaction yields one result with the bin count; a
// list transaction walks the break bitmap with one find-lowest-set unit and yields
// one bin per cycle while m_ready stays high, one more bin than there are breaks.
// The input is not ready while a transaction is in progress. The output register
// lets the last result wait while the next transaction is accepted. The final bin
// of a list ends at the positions_in_use register, written through cfg_wr_en.
module break_bitmap_bin_enumerator_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bbbe_pkg::BIT_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bbbe_pkg::FUNC_W-1:0]  s_func,
    input  logic [bbbe_pkg::BIT_W-1:0]   s_position,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bbbe_pkg::BIT_W-1:0]   m_bin_start,
    output logic [bbbe_pkg::BIT_W-1:0]   m_bin_end,
    output logic [bbbe_pkg::COUNT_W-1:0] m_bin_count,
    output logic                         m_last
);
    import bbbe_pkg::*;

    state_t               state_reg, state_next;
    logic [BIT_W-1:0]     piu_reg;
    logic [MAP_W-1:0]     map_reg, map_next;
    logic [COUNT_W-1:0]   bins_reg, bins_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [BIT_W-1:0]     pos_reg, pos_next;
    logic [MAP_W-1:0]     scan_reg, scan_next;
    logic [BIT_W-1:0]     start_reg, start_next;
    logic                 m_valid_reg, m_valid_next;
    logic [BIT_W-1:0]     m_start_reg, m_start_next;
    logic [BIT_W-1:0]     m_end_reg, m_end_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;
    logic                 m_last_reg, m_last_next;

    ffs_res_t             ffs;
    logic                 out_free;
    logic                 in_range;
    logic [MAP_W-1:0]     pos_mask;
    logic                 was_set;
    logic                 set_it;

    bbbe_ffs u_ffs (
        .vec (scan_reg),
        .res (ffs)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign in_range = (pos_reg < piu_reg) && (pos_reg < BIT_W'(MAX_BREAKS));
    assign pos_mask = MAP_W'(1) << pos_reg;
    assign was_set  = |(map_reg & pos_mask);

    always_comb begin
        unique case (func_reg)
            FUNC_INSERT: set_it = 1'b1;
            FUNC_REMOVE: set_it = 1'b0;
            FUNC_TOGGLE: set_it = !was_set;
            default:     set_it = was_set;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        map_next      = map_reg;
        bins_next     = bins_reg;
        func_next     = func_reg;
        pos_next      = pos_reg;
        scan_next     = scan_reg;
        start_next    = start_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_start_next  = m_start_reg;
        m_end_next    = m_end_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        s_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next  = s_func;
                    pos_next   = s_position;
                    scan_next  = map_reg;
                    start_next = '0;
                    state_next = (s_func == FUNC_LIST) ? ST_LIST : ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    if (in_range && set_it && !was_set) begin
                        map_next  = map_reg | pos_mask;
                        bins_next = bins_reg + COUNT_W'(1);
                    end else if (in_range && !set_it && was_set) begin
                        map_next  = map_reg & ~pos_mask;
                        bins_next = bins_reg - COUNT_W'(1);
                    end
                    m_valid_next = 1'b1;
                    m_start_next = '0;
                    m_end_next   = '0;
                    m_count_next = bins_next;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_LIST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_start_next = start_reg;
                    m_count_next = bins_reg;
                    if (ffs.found) begin
                        m_end_next  = ffs.idx;
                        m_last_next = 1'b0;
                        scan_next   = ffs.rest;
                        start_next  = ffs.idx + BIT_W'(1);
                    end else begin
                        // No break left: the final bin closes at the register value.
                        m_end_next  = piu_reg;
                        m_last_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piu_reg     <= PIU_RESET;
            map_reg     <= '0;
            bins_reg    <= COUNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                piu_reg <= cfg_wr_data;
            end
            map_reg     <= map_next;
            bins_reg    <= bins_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        pos_reg     <= pos_next;
        scan_reg    <= scan_next;
        start_reg   <= start_next;
        m_start_reg <= m_start_next;
        m_end_reg   <= m_end_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_start = m_start_reg;
    assign m_bin_end   = m_end_reg;
    assign m_bin_count = m_count_reg;
    assign m_last      = m_last_reg;

endmodule

// File: rtl/bbbe_checker.sv
// Port-level checker of the break bitmap bin enumerator and its bind statement.
`include "break_bitmap_bin_enumerator_core_assert.svh"

module bbbe_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [bbbe_pkg::BIT_W-1:0]   m_bin_start,
    input logic [bbbe_pkg::BIT_W-1:0]   m_bin_end,
    input logic [bbbe_pkg::COUNT_W-1:0] m_bin_count,
    input logic                         m_last
);
    import bbbe_pkg::*;

    // A stalled result must hold its count and marker.
    `BBBE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_bin_count) && $stable(m_last), "stalled result changed")

    // Acceptance of a transaction leaves the block busy, with the input not ready.
    `BBBE_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready right after accept")

    // There is always at least one bin.
    `BBBE_ASSERT_NOW(a_count_nonzero, m_valid, m_bin_count != '0, "bin count is zero")

    // A bin that is not the final one ends at a break and starts no later than it ends.
    `BBBE_ASSERT_NOW(a_inner_bin, m_valid && !m_last, (m_bin_end < BIT_W'(MAX_BREAKS)) && (m_bin_start <= m_bin_end), "inner bin malformed")

endmodule

bind break_bitmap_bin_enumerator_core bbbe_checker u_bbbe_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_bin_start (m_bin_start),
    .m_bin_end   (m_bin_end),
    .m_bin_count (m_bin_count),
    .m_last      (m_last)
);
